/* sv/lsc_pkg.sv */
// ----------------------------------------------------------------------------
// lsc_pkg
// shared types for the lru slot cache: per-cell control group
// ----------------------------------------------------------------------------
package lsc_pkg;

    // control handed from the sequencer to every cell of the chain
    typedef struct packed {
        logic clear;   // drop the cell's entry
        logic shift;   // take the neighbor's entry
    } lsc_cell_ctl_t;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_ALLOC  = 1'b1;

endpackage

/* sv/lsc_ifs.sv */
// ----------------------------------------------------------------------------
// lsc_ifs
// valid/ready channels of the lru slot cache: request, result, config write
// ----------------------------------------------------------------------------
interface lsc_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [63:0] key;

    modport source (output valid, output command, output key, input ready);
    modport sink   (input valid, input command, input key, output ready);
endinterface

interface lsc_rsp_if #(parameter int COUNT_BITS = 32);
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [7:0]            slot;
    logic                  evicted;
    logic [63:0]           evicted_key;
    logic [COUNT_BITS-1:0] use_count;
    logic [COUNT_BITS-1:0] access_stamp;
    logic [COUNT_BITS-1:0] lookup_total;
    logic [COUNT_BITS-1:0] hit_total;
    logic [COUNT_BITS-1:0] eviction_total;
    logic [8:0]            resident_count;

    modport source (output valid, output hit, output slot, output evicted,
                    output evicted_key, output use_count, output access_stamp,
                    output lookup_total, output hit_total, output eviction_total,
                    output resident_count, input ready);
    modport sink   (input valid, input hit, input slot, input evicted,
                    input evicted_key, input use_count, input access_stamp,
                    input lookup_total, input hit_total, input eviction_total,
                    input resident_count, output ready);
endinterface

interface lsc_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/lru_slot_cache.sv */
// ----------------------------------------------------------------------------
// lru_slot_cache
// fully associative key-to-slot tag store with lru replacement, built as a
// chain of recency-ordered cells (cell 0 most recent)
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid/ready    command, key
//  rsp      out  valid/ready    hit, slot, evicted, evicted_key, counts, totals
//  cfg      in   valid/ready    data (capacity_slots), ready always high
//
//  the accept cycle compares the key in every cell and registers the hit
//  position; the update state then moves the chain and loads the result
//  register, and waits while the result register is still full; no new
//  request is taken until the update is done
//  a config write clears all cells and counters at once
//  reset: async active low, capacity back to SLOTS (clamped to 256)
// ----------------------------------------------------------------------------
module lru_slot_cache
    import lsc_pkg::*;
#(
    parameter int SLOTS      = 256,
    parameter int COUNT_BITS = 32
)(
    input  logic                       clk,
    input  logic                       rst_n,
    lsc_req_if.sink                    req,
    lsc_rsp_if.source                  rsp,
    lsc_cfg_if.sink                    cfg
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W = $clog2(SLOTS + 1);
    localparam int CB     = COUNT_BITS;
    localparam int RESET_CAP = (SLOTS < 256) ? SLOTS : 256;
    localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_UPDATE = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // item registers
    logic              cmd_reg;
    logic [63:0]       key_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] hpos_reg;

    // block state
    logic [FILL_W-1:0] cap_reg;
    logic [FILL_W-1:0] fresh_reg;
    logic [CB-1:0]     clock_reg;
    logic [CB-1:0]     lookups_reg;
    logic [CB-1:0]     hits_reg;
    logic [CB-1:0]     evicts_reg;

    // result register
    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [7:0]        out_slot_reg;
    logic              out_ev_reg;
    logic [63:0]       out_evkey_reg;
    logic [CB-1:0]     out_uses_reg;
    logic [CB-1:0]     out_stamp_reg;
    logic [CB-1:0]     out_lookups_reg;
    logic [CB-1:0]     out_hits_reg;
    logic [CB-1:0]     out_evicts_reg;
    logic [8:0]        out_res_reg;

    // chain signals
    lsc_cell_ctl_t     ctl     [SLOTS];
    logic              c_valid [SLOTS];
    logic [63:0]       c_tag   [SLOTS];
    logic [SLOT_W-1:0] c_slot  [SLOTS];
    logic [CB-1:0]     c_uses  [SLOTS];
    logic [CB-1:0]     c_stamp [SLOTS];
    logic [SLOTS-1:0]  match;

    logic              in_acc;
    logic              cfg_acc;
    logic              out_free;
    logic              go;
    logic [SLOT_W-1:0] hpos;

    // update-cycle decode
    logic              full;
    logic              do_move;
    logic              do_fresh;
    logic              do_evict;
    logic [SLOT_W-1:0] pos;
    logic [SLOT_W-1:0] new_slot;
    logic [CB-1:0]     new_uses;
    logic [CB-1:0]     new_stamp;
    logic [CB-1:0]     lookups_next;
    logic [CB-1:0]     hits_next;
    logic [CB-1:0]     evicts_next;
    logic [FILL_W-1:0] fresh_next;
    logic [FILL_W-1:0] cap_next;

    assign in_acc   = req.valid && req.ready;
    assign cfg_acc  = cfg.valid && cfg.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign go       = (state_reg == S_UPDATE) && out_free;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    // ---- cells ----
    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            logic              p_valid;
            logic [63:0]       p_tag;
            logic [SLOT_W-1:0] p_slot;
            logic [CB-1:0]     p_uses;
            logic [CB-1:0]     p_stamp;

            if (gi == 0)
            begin : g_head
                // head cell takes the promoted or new entry
                assign p_valid = 1'b1;
                assign p_tag   = key_reg;
                assign p_slot  = new_slot;
                assign p_uses  = new_uses;
                assign p_stamp = new_stamp;
            end
            else
            begin : g_body
                assign p_valid = c_valid[gi-1];
                assign p_tag   = c_tag[gi-1];
                assign p_slot  = c_slot[gi-1];
                assign p_uses  = c_uses[gi-1];
                assign p_stamp = c_stamp[gi-1];
            end

            // cells at or newer than the moved position step one older
            assign ctl[gi] = '{clear: cfg_acc,
                               shift: go && do_move && (SLOT_W'(gi) <= pos)};

            lsc_cell #(.SLOT_W(SLOT_W), .CB(CB)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl[gi]),
                .prev_valid (p_valid),
                .prev_tag   (p_tag),
                .prev_slot  (p_slot),
                .prev_uses  (p_uses),
                .prev_stamp (p_stamp),
                .key        (req.key),
                .valid      (c_valid[gi]),
                .tag        (c_tag[gi]),
                .slot       (c_slot[gi]),
                .uses       (c_uses[gi]),
                .stamp      (c_stamp[gi]),
                .match      (match[gi])
            );
        end
    endgenerate

    // keys are unique, so the match vector has at most one bit set: encode with or-trees
    always_comb
    begin
        hpos = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (match[i])
            begin
                hpos = hpos | SLOT_W'(i);
            end
        end
    end

    // ---- update decode ----
    always_comb
    begin
        full     = (fresh_reg == cap_reg);
        do_move  = hit_reg || (cmd_reg == CMD_ALLOC);
        do_fresh = !hit_reg && (cmd_reg == CMD_ALLOC) && !full;
        do_evict = !hit_reg && (cmd_reg == CMD_ALLOC) && full;

        if (hit_reg)
        begin
            pos = hpos_reg;
        end
        else if (full)
        begin
            // least recent entry sits at the last occupied position
            pos = SLOT_W'(fresh_reg - FILL_W'(1));
        end
        else
        begin
            pos = SLOT_W'(fresh_reg);
        end

        new_stamp = clock_reg + CB'(1);
        if (hit_reg)
        begin
            new_slot = c_slot[pos];
            new_uses = c_uses[pos] + CB'(1);
        end
        else if (full)
        begin
            new_slot = c_slot[pos];
            new_uses = CB'(1);
        end
        else
        begin
            new_slot = SLOT_W'(fresh_reg);
            new_uses = CB'(1);
        end

        lookups_next = lookups_reg;
        hits_next    = hits_reg;
        evicts_next  = evicts_reg;
        if (cmd_reg == CMD_LOOKUP)
        begin
            if (lookups_reg != CNT_MAX) lookups_next = lookups_reg + CB'(1);
            if (hit_reg && hits_reg != CNT_MAX) hits_next = hits_reg + CB'(1);
        end
        if (do_evict && evicts_reg != CNT_MAX)
        begin
            evicts_next = evicts_reg + CB'(1);
        end
        fresh_next = do_fresh ? fresh_reg + FILL_W'(1) : fresh_reg;

        // capacity clamp: zero acts as one, above SLOTS acts as SLOTS
        if (cfg.data == 9'd0)
        begin
            cap_next = FILL_W'(1);
        end
        else if (int'(cfg.data) > SLOTS)
        begin
            cap_next = FILL_W'(SLOTS);
        end
        else
        begin
            cap_next = FILL_W'(cfg.data);
        end
    end

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_acc) state_next = S_UPDATE;
            S_UPDATE: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cap_reg       <= FILL_W'(RESET_CAP);
            fresh_reg     <= '0;
            clock_reg     <= '0;
            lookups_reg   <= '0;
            hits_reg      <= '0;
            evicts_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_acc)
            begin
                cap_reg     <= cap_next;
                fresh_reg   <= '0;
                clock_reg   <= '0;
                lookups_reg <= '0;
                hits_reg    <= '0;
                evicts_reg  <= '0;
            end
            else if (go)
            begin
                fresh_reg   <= fresh_next;
                lookups_reg <= lookups_next;
                hits_reg    <= hits_next;
                evicts_reg  <= evicts_next;
                if (do_move) clock_reg <= new_stamp;
            end
        end
    end

    // item capture and result payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg  <= req.command;
            key_reg  <= req.key;
            hit_reg  <= |match;
            hpos_reg <= hpos;
        end
        if (go)
        begin
            out_hit_reg     <= hit_reg;
            out_slot_reg    <= do_move ? 8'(new_slot) : 8'd0;
            out_ev_reg      <= do_evict;
            out_evkey_reg   <= do_evict ? c_tag[pos] : 64'd0;
            out_uses_reg    <= do_move ? new_uses : '0;
            out_stamp_reg   <= do_move ? new_stamp : '0;
            out_lookups_reg <= lookups_next;
            out_hits_reg    <= hits_next;
            out_evicts_reg  <= evicts_next;
            out_res_reg     <= 9'(fresh_next);
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.hit            = out_hit_reg;
    assign rsp.slot           = out_slot_reg;
    assign rsp.evicted        = out_ev_reg;
    assign rsp.evicted_key    = out_evkey_reg;
    assign rsp.use_count      = out_uses_reg;
    assign rsp.access_stamp   = out_stamp_reg;
    assign rsp.lookup_total   = out_lookups_reg;
    assign rsp.hit_total      = out_hits_reg;
    assign rsp.eviction_total = out_evicts_reg;
    assign rsp.resident_count = out_res_reg;

    // ---- assertions ----
    // resident keys are unique, so at most one cell matches
    a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("more than one cell matches the key");

    // fill count never exceeds capacity
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= cap_reg)
        else $error("fill count above capacity");

    // a capacity write empties the store
    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_acc |=> (fresh_reg == '0) && !c_valid[0])
        else $error("capacity write did not clear the store");

endmodule

/* sv/lsc_cell.sv */
// ----------------------------------------------------------------------------
// lsc_cell
// one recency position of the lru chain: entry storage and key compare
// ----------------------------------------------------------------------------
module lsc_cell
    import lsc_pkg::*;
#(
    parameter int SLOT_W = 8,
    parameter int CB     = 32
)(
    input  logic              clk,
    input  logic              rst_n,
    input  lsc_cell_ctl_t     ctl,
    input  logic              prev_valid,
    input  logic [63:0]       prev_tag,
    input  logic [SLOT_W-1:0] prev_slot,
    input  logic [CB-1:0]     prev_uses,
    input  logic [CB-1:0]     prev_stamp,
    input  logic [63:0]       key,
    output logic              valid,
    output logic [63:0]       tag,
    output logic [SLOT_W-1:0] slot,
    output logic [CB-1:0]     uses,
    output logic [CB-1:0]     stamp,
    output logic              match
);

    logic              valid_reg;
    logic [63:0]       tag_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CB-1:0]     uses_reg;
    logic [CB-1:0]     stamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            tag_reg   <= prev_tag;
            slot_reg  <= prev_slot;
            uses_reg  <= prev_uses;
            stamp_reg <= prev_stamp;
        end
    end

    assign valid = valid_reg;
    assign tag   = tag_reg;
    assign slot  = slot_reg;
    assign uses  = uses_reg;
    assign stamp = stamp_reg;
    assign match = valid_reg && (tag_reg == key);

endmodule
